// ===== design/wts_pkg.sv =====
// ---------------------------------------------------------------------------
// wts_pkg: shared types and constants for the word tokenize and sort core
// Slot count, word width, delimiter codes and the record that one sorting
// cell holds.
// ---------------------------------------------------------------------------
package wts_pkg;

  localparam int WORD_SLOTS = 32;
  localparam int WORD_CHARS = 8;

  // bits of a word-count that can hold WORD_SLOTS itself
  localparam int TOTAL_W = $clog2(WORD_SLOTS + 1);

  localparam logic [7:0] CHAR_SPACE  = 8'd32;
  localparam logic [7:0] CHAR_PERIOD = 8'd46;
  localparam logic [7:0] CHAR_COMMA  = 8'd44;
  localparam logic [7:0] CHAR_SEMI   = 8'd59;
  localparam logic [7:0] CHAR_NUL    = 8'd0;

  // one stored word
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  len;
    logic        trunc;
  } entry_t;

  // word handed from the tokenizer to the sorting chain
  typedef struct packed {
    logic   req;
    entry_t entry;
  } close_t;

  // per-cell control from the top level
  typedef struct packed {
    logic insert;
    logic shift;
    logic beyond;
  } cell_ctl_t;

  function automatic logic is_delim(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_PERIOD) ||
           (c == CHAR_COMMA) || (c == CHAR_SEMI);
  endfunction

endpackage

// ===== design/wts_in_if.sv =====
// ---------------------------------------------------------------------------
// wts_in_if: sentence byte channel
// One beat carries one byte and the end-of-sentence flag.
// ---------------------------------------------------------------------------
interface wts_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       final_byte;

  modport source (output valid, output char_byte, output final_byte, input ready);
  modport sink   (input valid, input char_byte, input final_byte, output ready);
endinterface

// ===== design/wts_out_if.sv =====
// ---------------------------------------------------------------------------
// wts_out_if: sorted word channel
// One beat carries one sorted word and its flags.
// ---------------------------------------------------------------------------
interface wts_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] word_packed;
  logic [3:0]  word_length;
  logic        word_truncated;
  logic        words_dropped;
  logic        last_word;

  modport source (output valid, output word_packed, output word_length,
                  output word_truncated, output words_dropped, output last_word,
                  input ready);
  modport sink   (input valid, input word_packed, input word_length,
                  input word_truncated, input words_dropped, input last_word,
                  output ready);
endinterface

// ===== design/wts_tokenizer.sv =====
// ---------------------------------------------------------------------------
// wts_tokenizer: byte to word assembly
// Packs word characters big-endian, marks truncation, and hands a closed
// word to the sorting chain on a delimiter, a zero byte or the final byte.
// ---------------------------------------------------------------------------
module wts_tokenizer
  import wts_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       beat,
  input  logic [7:0] char_byte,
  input  logic       final_byte,
  output close_t     closed
);

  logic [63:0] cur_word;
  logic [3:0]  cur_len;
  logic        cur_trunc;
  logic        ended;

  entry_t after;
  logic   brk;
  logic   is_char;

  // byte classification and append
  always_comb begin
    after.word  = cur_word;
    after.len   = cur_len;
    after.trunc = cur_trunc;
    brk         = !ended && ((char_byte == CHAR_NUL) || is_delim(char_byte));
    is_char     = !ended && !brk;
    if (is_char) begin
      if (cur_len < 4'(WORD_CHARS)) begin
        for (int b = 0; b < 8; b++) begin
          if (cur_len == 4'(b)) after.word[63-8*b -: 8] = char_byte;
        end
        after.len = cur_len + 4'd1;
      end else begin
        after.trunc = 1'b1;
      end
    end
    closed.req   = beat && (brk || final_byte);
    closed.entry = after;
  end

  // current word and content-ended flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_word  <= '0;
      cur_len   <= '0;
      cur_trunc <= 1'b0;
      ended     <= 1'b0;
    end else if (beat) begin
      if (closed.req) begin
        cur_word  <= '0;
        cur_len   <= '0;
        cur_trunc <= 1'b0;
      end else begin
        cur_word  <= after.word;
        cur_len   <= after.len;
        cur_trunc <= after.trunc;
      end
      if (final_byte)                      ended <= 1'b0;
      else if (!ended && char_byte == CHAR_NUL) ended <= 1'b1;
    end
  end

endmodule

// ===== design/wts_cell.sv =====
// ---------------------------------------------------------------------------
// wts_cell: one slot of the insertion-sort chain
// On insert, a cell whose word is greater than the new one (or that lies
// past the fill count) takes its left neighbor's word, or the new word if
// it is the first such cell. On drain, each cell takes its right neighbor.
// ---------------------------------------------------------------------------
module wts_cell
  import wts_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  entry_t    new_entry,
  input  entry_t    left_entry,
  input  logic      left_take,
  input  entry_t    right_entry,
  output entry_t    entry,
  output logic      take
);

  // strict compare keeps equal words in arrival order
  assign take = ctl.beyond || (entry.word > new_entry.word);

  always_ff @(posedge clk) begin
    if (ctl.insert && take) begin
      entry <= left_take ? left_entry : new_entry;
    end else if (ctl.shift) begin
      entry <= right_entry;
    end
  end

endmodule

// ===== design/word_tokenize_and_sort_core.sv =====
// ---------------------------------------------------------------------------
// word_tokenize_and_sort_core: sentence tokenizer with sorted word output
//
//   channel | dir | payload
//   chars   | in  | char_byte[7:0], final_byte
//   words   | out | word_packed[63:0], word_length[3:0], word_truncated,
//           |     | words_dropped, last_word
//
// One byte per cycle is taken while a sentence arrives; each closed word is
// inserted into the cell chain in the cycle that closes it, or dropped and
// flagged when all slots are full. After the final byte, the chain drains
// one word per cycle from cell 0 and chars.ready stays low until the last
// word beat. Reset is synchronous; an output stall simply holds the chain.
// ---------------------------------------------------------------------------
module word_tokenize_and_sort_core
  import wts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  wts_in_if.sink    chars,
  wts_out_if.source words
);

  logic [TOTAL_W-1:0] total;
  logic               draining;
  logic               overflow;

  close_t closed;
  logic   in_beat;
  logic   out_beat;
  logic   full;
  logic   do_insert;
  logic   drop_word;

  entry_t    cells [WORD_SLOTS];
  logic      takes [WORD_SLOTS];
  cell_ctl_t ctls  [WORD_SLOTS];

  assign chars.ready = !draining;
  assign in_beat     = chars.valid && chars.ready;
  assign out_beat    = words.valid && words.ready;

  wts_tokenizer u_tok (
    .clk        (clk),
    .rst        (rst),
    .beat       (in_beat),
    .char_byte  (chars.char_byte),
    .final_byte (chars.final_byte),
    .closed     (closed)
  );

  // insert / drop decision
  assign full      = (total == TOTAL_W'(WORD_SLOTS));
  assign do_insert = closed.req && (closed.entry.len != 4'd0) && !full;
  assign drop_word = closed.req && (closed.entry.len != 4'd0) && full;

  // sorting chain
  for (genvar i = 0; i < WORD_SLOTS; i++) begin : g_cell
    assign ctls[i].insert = do_insert;
    assign ctls[i].shift  = out_beat;
    assign ctls[i].beyond = (TOTAL_W'(i) >= total);
    wts_cell u_cell (
      .clk         (clk),
      .ctl         (ctls[i]),
      .new_entry   (closed.entry),
      .left_entry  ((i == 0) ? closed.entry : cells[(i == 0) ? 0 : i-1]),
      .left_take   ((i == 0) ? 1'b0 : takes[(i == 0) ? 0 : i-1]),
      .right_entry (cells[(i == WORD_SLOTS-1) ? i : i+1]),
      .entry       (cells[i]),
      .take        (takes[i])
    );
  end

  // fill count, drain state and overflow flag
  always_ff @(posedge clk) begin
    if (rst) begin
      total    <= '0;
      draining <= 1'b0;
      overflow <= 1'b0;
    end else if (in_beat) begin
      if (do_insert) total <= total + TOTAL_W'(1);
      if (chars.final_byte) begin
        draining <= do_insert || (total != '0);
        if (!(do_insert || (total != '0))) overflow <= 1'b0;
        else if (drop_word)                overflow <= 1'b1;
      end else if (drop_word) begin
        overflow <= 1'b1;
      end
    end else if (out_beat) begin
      total <= total - TOTAL_W'(1);
      if (total == TOTAL_W'(1)) begin
        draining <= 1'b0;
        overflow <= 1'b0;
      end
    end
  end

  // result beat straight from cell 0
  assign words.valid          = draining;
  assign words.word_packed    = cells[0].word;
  assign words.word_length    = cells[0].len;
  assign words.word_truncated = cells[0].trunc;
  assign words.words_dropped  = overflow;
  assign words.last_word      = (total == TOTAL_W'(1));

  // checks
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(chars.ready && words.valid))
    else $error("input taken while draining");

  a_drain_nonempty: assert property (@(posedge clk) disable iff (rst)
    words.valid |-> (total != '0))
    else $error("draining with empty chain");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (words.valid && words.ready && words.last_word) |=> !words.valid)
    else $error("results after last word");

  a_total_range: assert property (@(posedge clk) disable iff (rst)
    total <= TOTAL_W'(WORD_SLOTS))
    else $error("fill count beyond slot count");

endmodule

// ===== tb/sv/tb_word_tokenize_and_sort_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_word_tokenize_and_sort_core: self-checking bench for the sentence sorter
// Feeds sentences byte by byte and predicts the sorted words of each one
// with a behavioral insertion sort. Every word beat is checked against the
// oldest prediction. Both channels idle at random, and the word side also
// holds off for one long stretch.
// ---------------------------------------------------------------------------
module tb_word_tokenize_and_sort_core;
  import wts_pkg::*;

  // one pending sentence byte; drain_first holds it back until all words are out
  typedef struct {
    logic [7:0] char_byte;
    logic       final_byte;
    bit         drain_first;
  } byte_beat_t;

  // one predicted word beat
  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  len;
    logic        trunc;
    logic        dropped;
    logic        last;
  } word_beat_t;

  logic clk;
  logic rst;

  wts_in_if  chars_if();
  wts_out_if words_if();

  word_tokenize_and_sort_core dut (
    .clk   (clk),
    .rst   (rst),
    .chars (chars_if),
    .words (words_if)
  );

  always #5 clk = ~clk;

  byte_beat_t byte_q[$];
  word_beat_t sorted_q[$];

  int words_predicted = 0;
  int words_seen      = 0;
  int byte_count      = 0;
  int mismatches      = 0;

  // sorter model state
  entry_t      sorted_words[WORD_SLOTS];
  int          held_count       = 0;
  logic [63:0] open_word        = '0;
  int          open_len         = 0;
  logic        open_trunc       = 1'b0;
  bit          after_nul        = 1'b0;
  bit          slots_overflowed = 1'b0;

  function automatic bit is_separator(input logic [7:0] c);
    case (c)
      CHAR_SPACE, CHAR_PERIOD, CHAR_COMMA, CHAR_SEMI: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // close the open word: stable insert after equal words, or drop when full
  function automatic void file_open_word();
    int pos;
    int i;
    if (open_len != 0) begin
      if (held_count >= WORD_SLOTS) begin
        slots_overflowed = 1'b1;
      end else begin
        pos = held_count;
        for (i = held_count - 1; i >= 0; i--)
          if (sorted_words[i].word > open_word) pos = i;
        for (i = held_count; i > pos; i--)
          sorted_words[i] = sorted_words[i - 1];
        sorted_words[pos].word  = open_word;
        sorted_words[pos].len   = open_len[3:0];
        sorted_words[pos].trunc = open_trunc;
        held_count++;
      end
    end
    open_word  = '0;
    open_len   = 0;
    open_trunc = 1'b0;
  endfunction

  // apply one accepted byte; returns the number of word beats it releases
  function automatic int take_byte(input logic [7:0] c, input logic fin);
    word_beat_t b;
    int i;
    int n;
    if (!after_nul) begin
      if (c == CHAR_NUL) begin
        file_open_word();
        after_nul = 1'b1;
      end else if (is_separator(c)) begin
        file_open_word();
      end else if (open_len < WORD_CHARS) begin
        open_word[63 - 8 * open_len -: 8] = c;
        open_len++;
      end else begin
        open_trunc = 1'b1;
      end
    end
    if (!fin) return 0;
    if (!after_nul) file_open_word();
    n = held_count;
    for (i = 0; i < n; i++) begin
      b.word    = sorted_words[i].word;
      b.len     = sorted_words[i].len;
      b.trunc   = sorted_words[i].trunc;
      b.dropped = slots_overflowed;
      b.last    = (i == n - 1);
      sorted_q.push_back(b);
    end
    held_count       = 0;
    after_nul        = 1'b0;
    slots_overflowed = 1'b0;
    return n;
  endfunction

  // ---------------- stimulus helpers ----------------
  task automatic add_byte(input logic [7:0] c, input logic fin, input bit drain_first);
    byte_beat_t b;
    b.char_byte   = c;
    b.final_byte  = fin;
    b.drain_first = drain_first;
    byte_q.push_back(b);
  endtask

  function automatic logic [7:0] pick_delim();
    case ($urandom_range(0, 3))
      0:       return CHAR_SPACE;
      1:       return CHAR_PERIOD;
      2:       return CHAR_COMMA;
      default: return CHAR_SEMI;
    endcase
  endfunction

  // narrow alphabet makes equal and prefix words common
  function automatic logic [7:0] word_letter(input bit narrow);
    logic [7:0] c;
    if (narrow) return 8'h61 + 8'($urandom_range(0, 2));
    do c = 8'($urandom_range(1, 255)); while (is_separator(c));
    return c;
  endfunction

  task automatic add_sentence(input int n_words, input bit drain_first);
    int  w;
    int  k;
    int  len;
    int  gap;
    bit  narrow;
    bit  first;
    first  = drain_first;
    narrow = ($urandom_range(0, 1) == 1);
    if ($urandom_range(0, 4) == 0) begin
      add_byte(pick_delim(), 1'b0, first);
      first = 1'b0;
    end
    for (w = 0; w < n_words; w++) begin
      len = ($urandom_range(0, 5) == 0) ? $urandom_range(8, 11) : $urandom_range(1, 4);
      for (k = 0; k < len; k++) begin
        add_byte(word_letter(narrow), 1'b0, first);
        first = 1'b0;
      end
      if (w != n_words - 1) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 3) : 1;
        repeat (gap) add_byte(pick_delim(), 1'b0, 1'b0);
      end
    end
    // how the sentence ends
    case ($urandom_range(0, 9))
      0, 1, 2, 3: add_byte(pick_delim(), 1'b1, 1'b0);
      4, 5:       add_byte(word_letter(narrow), 1'b1, 1'b0);
      6:          add_byte(CHAR_NUL, 1'b1, 1'b0);
      7, 8: begin
        add_byte(CHAR_NUL, 1'b0, 1'b0);
        repeat ($urandom_range(0, 3)) add_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end
      default: begin
        add_byte(pick_delim(), 1'b0, 1'b0);
        add_byte(pick_delim(), 1'b1, 1'b0);
      end
    endcase
  endtask

  // ---------------- byte driver ----------------
  always @(posedge clk) begin : drive_chars
    byte_beat_t head;
    int  n;
    bit  quiet;
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else begin
      n = 0;
      if (chars_if.valid && chars_if.ready) begin
        head = byte_q.pop_front();
        n = take_byte(head.char_byte, head.final_byte);
        words_predicted <= words_predicted + n;
        byte_count      <= byte_count + 1;
      end
      // no idling over a window of the random part
      quiet = !(byte_count >= 300 && byte_count < 380) && ($urandom_range(0, 99) < 35);
      if (chars_if.valid && !chars_if.ready) begin
        // beat still offered, hold it
      end else if (byte_q.size() != 0 && !quiet &&
                   !(byte_q[0].drain_first && (words_predicted + n != words_seen))) begin
        chars_if.valid      <= 1'b1;
        chars_if.char_byte  <= byte_q[0].char_byte;
        chars_if.final_byte <= byte_q[0].final_byte;
      end else begin
        chars_if.valid <= 1'b0;
      end
    end
  end

  // ---------------- word monitor ----------------
  int hold_left = 0;
  bit hold_done = 1'b0;

  always @(posedge clk) begin : watch_words
    word_beat_t got;
    word_beat_t want;
    if (rst) begin
      words_if.ready <= 1'b0;
    end else begin
      if (words_if.valid && words_if.ready) begin
        got = {words_if.word_packed, words_if.word_length, words_if.word_truncated,
               words_if.words_dropped, words_if.last_word};
        words_seen <= words_seen + 1;
        if (sorted_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected word beat %h len %0d", $realtime, got.word, got.len);
          mismatches++;
        end else begin
          want = sorted_q.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display("%0t: word mismatch exp %h/%0d/t%b/d%b/l%b got %h/%0d/t%b/d%b/l%b",
                       $realtime, want.word, want.len, want.trunc, want.dropped, want.last,
                       got.word, got.len, got.trunc, got.dropped, got.last);
            mismatches++;
          end
        end
      end
      // one long hold-off early on, so the input side backs up behind it
      if (hold_left > 0) begin
        hold_left--;
        words_if.ready <= 1'b0;
      end else if (!hold_done && byte_count >= 150) begin
        hold_done = 1'b1;
        hold_left = 400;
        words_if.ready <= 1'b0;
      end else begin
        words_if.ready <= (words_seen >= 40 && words_seen < 90) ||
                          ($urandom_range(0, 99) >= 35);
      end
    end
  end

  // ---------------- run control ----------------
  initial begin
    int sentence_no;
    int first_random;
    int n_words;
    clk = 1'b0;
    rst = 1'b1;
    chars_if.valid      = 1'b0;
    chars_if.char_byte  = '0;
    chars_if.final_byte = 1'b0;
    words_if.ready      = 1'b0;

    // extreme bytes, repeated delimiters, duplicates, final on a delimiter
    add_byte(8'hFF, 1'b0, 1'b0);
    add_byte(8'h01, 1'b0, 1'b0);
    add_byte(CHAR_SPACE, 1'b0, 1'b0);
    add_byte(CHAR_SPACE, 1'b0, 1'b0);
    add_byte("b", 1'b0, 1'b0);
    add_byte(CHAR_PERIOD, 1'b0, 1'b0);
    add_byte("a", 1'b0, 1'b0);
    add_byte(CHAR_COMMA, 1'b0, 1'b0);
    add_byte("a", 1'b0, 1'b0);
    add_byte(CHAR_SEMI, 1'b1, 1'b0);
    // long word, final byte is a word character
    repeat (9) add_byte("q", 1'b0, 1'b0);
    add_byte("q", 1'b1, 1'b0);
    // zero byte ends content, trailing bytes ignored, final on zero
    add_byte("x", 1'b0, 1'b0);
    add_byte(CHAR_NUL, 1'b0, 1'b0);
    add_byte("y", 1'b0, 1'b0);
    add_byte(CHAR_NUL, 1'b1, 1'b0);
    // sentence with no word at all
    add_byte(CHAR_SPACE, 1'b1, 1'b0);

    // random sentences, a few sized at and past the slot count
    sentence_no  = 0;
    first_random = byte_q.size();
    while (byte_q.size() - first_random < 460) begin
      if (sentence_no == 3)       n_words = WORD_SLOTS + 4;
      else if (sentence_no == 7)  n_words = WORD_SLOTS;
      else if (sentence_no == 14) n_words = WORD_SLOTS + 1;
      else                        n_words = $urandom_range(1, 6);
      if ($urandom_range(0, 19) == 0) begin
        // noise sentence
        repeat ($urandom_range(1, 20)) add_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        add_byte(8'($urandom_range(0, 255)), 1'b1, 1'b0);
      end else begin
        add_sentence(n_words, sentence_no == 0 || sentence_no == 12);
      end
      sentence_no++;
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (byte_q.size() != 0 || chars_if.valid || words_seen != words_predicted)
      @(posedge clk);
    repeat (50) @(posedge clk);

    if (mismatches == 0 && sorted_q.size() == 0) begin
      $display("PASS word_tokenize_and_sort_core");
    end else begin
      $display("FAIL word_tokenize_and_sort_core");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAIL word_tokenize_and_sort_core");
    $finish;
  end

endmodule

// ===== sim.f =====
design/wts_pkg.sv
design/wts_in_if.sv
design/wts_out_if.sv
design/wts_tokenizer.sv
design/wts_cell.sv
design/word_tokenize_and_sort_core.sv
tb/sv/tb_word_tokenize_and_sort_core.sv
